### hdl/fifo_mutex_lock_unit_core_macros.svh
// Assertion macros for the lock unit
`ifndef FIFO_MUTEX_LOCK_UNIT_CORE_MACROS_SVH
`define FIFO_MUTEX_LOCK_UNIT_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define FMLU_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("fmlu assertion failed");

`define FMLU_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("fmlu assertion failed");

`else

`define FMLU_ASSERT(name, clk, rst_n, prop)

`define FMLU_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

### hdl/fmlu_pkg.sv
package fmlu_pkg;

	localparam int OP_W      = 1;
	localparam int IDX_W     = 2;
	localparam int ID_W      = 4;
	localparam int OUTCOME_W = 3;

	localparam logic [OP_W-1:0] OP_WAIT   = 1'b0;
	localparam logic [OP_W-1:0] OP_SIGNAL = 1'b1;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_GRANTED  = 3'd0,
		OUT_QUEUED   = 3'd1,
		OUT_FULL     = 3'd2,
		OUT_HANDED   = 3'd3,
		OUT_RELEASED = 3'd4,
		OUT_IGNORED  = 3'd5
	} outcome_t;

	typedef enum logic [0:0] {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} dp_cmd_t;

endpackage

### hdl/fmlu_ctrl.sv
`include "fifo_mutex_lock_unit_core_macros.svh"

module fmlu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output fmlu_pkg::dp_cmd_t  cmd
);
	import fmlu_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nx;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (slot_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				cmd.commit = slot_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`FMLU_ASSERT(a_accept_to_exec, clk, arst_n, (in_valid && !in_stall) |=> (state_q == ST_EXEC))
	`FMLU_ASSERT(a_commit_slot_free, clk, arst_n, cmd.commit |-> (state_q == ST_EXEC && slot_free))
	`FMLU_ASSERT(a_commit_shows_beat, clk, arst_n, cmd.commit |=> out_valid)
	`FMLU_ASSERT(a_one_item_in_flight, clk, arst_n, (state_q == ST_EXEC) |-> (in_stall && !cmd.capture))

endmodule

### hdl/fmlu_dp.sv
module fmlu_dp #(
	parameter int LOCK_COUNT      = 4,
	parameter int QUEUE_DEPTH     = 8,
	parameter int REQUESTER_COUNT = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fmlu_pkg::dp_cmd_t                  cmd,
	input  logic [fmlu_pkg::OP_W-1:0]          operation,
	input  logic [fmlu_pkg::IDX_W-1:0]         lock_index,
	input  logic [fmlu_pkg::ID_W-1:0]          requester_id,
	output logic [fmlu_pkg::OUTCOME_W-1:0]     outcome,
	output logic                               woken_valid,
	output logic [fmlu_pkg::ID_W-1:0]          woken_id
);
	import fmlu_pkg::*;

	localparam int LOCK_W = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
	localparam int Q_W    = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	logic [ID_W-1:0]   mem [LOCK_COUNT][QUEUE_DEPTH];

	logic              held_q  [LOCK_COUNT];
	logic [ID_W-1:0]   owner_q [LOCK_COUNT];
	logic [Q_W-1:0]    head_q  [LOCK_COUNT];
	logic [CNT_W-1:0]  count_q [LOCK_COUNT];

	logic [OP_W-1:0]   op_q;
	logic [LOCK_W-1:0] lk_q;
	logic [ID_W-1:0]   who_q;
	logic              ok_q;
	logic [ID_W-1:0]   rd_q;

	logic [OUTCOME_W-1:0] outcome_q;
	logic                 woken_valid_q;
	logic [ID_W-1:0]      woken_id_q;

	logic              ok_in;
	logic [LOCK_W-1:0] lk_in;

	logic              cur_held;
	logic [ID_W-1:0]   cur_owner;
	logic [Q_W-1:0]    cur_head;
	logic [CNT_W-1:0]  cur_count;
	logic [CNT_W:0]    tail_sum;
	logic [Q_W-1:0]    tail;
	logic [Q_W-1:0]    head_nx;
	outcome_t          res;

	assign ok_in = (32'(lock_index) < LOCK_COUNT) && (32'(requester_id) < REQUESTER_COUNT);
	assign lk_in = ok_in ? LOCK_W'(lock_index) : '0;

	assign cur_held  = held_q[lk_q];
	assign cur_owner = owner_q[lk_q];
	assign cur_head  = head_q[lk_q];
	assign cur_count = count_q[lk_q];

	assign tail_sum = (CNT_W+1)'(cur_head) + (CNT_W+1)'(cur_count);
	assign tail     = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
		Q_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH)) : Q_W'(tail_sum);
	assign head_nx  = (cur_head == Q_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + Q_W'(1);

	always_comb begin
		if (!ok_q) begin
			res = OUT_IGNORED;
		end else if (op_q == OP_WAIT) begin
			if (!cur_held) begin
				res = OUT_GRANTED;
			end else if (cur_count == CNT_W'(QUEUE_DEPTH)) begin
				res = OUT_FULL;
			end else begin
				res = OUT_QUEUED;
			end
		end else if (!cur_held || cur_owner != who_q) begin
			res = OUT_IGNORED;
		end else if (cur_count != '0) begin
			res = OUT_HANDED;
		end else begin
			res = OUT_RELEASED;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= operation;
			lk_q  <= lk_in;
			who_q <= requester_id;
			ok_q  <= ok_in;
			rd_q  <= mem[lk_in][head_q[lk_in]];
		end
		if (cmd.commit && res == OUT_QUEUED) begin
			mem[lk_q][tail] <= who_q;
		end
		if (cmd.commit) begin
			outcome_q     <= res;
			woken_valid_q <= (res == OUT_HANDED);
			woken_id_q    <= (res == OUT_HANDED) ? rd_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LOCK_COUNT; i++) begin
				held_q[i]  <= 1'b0;
				owner_q[i] <= '0;
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			case (res)
				OUT_GRANTED: begin
					held_q[lk_q]  <= 1'b1;
					owner_q[lk_q] <= who_q;
				end
				OUT_QUEUED: begin
					count_q[lk_q] <= cur_count + CNT_W'(1);
				end
				OUT_HANDED: begin
					owner_q[lk_q] <= rd_q;
					head_q[lk_q]  <= head_nx;
					count_q[lk_q] <= cur_count - CNT_W'(1);
				end
				OUT_RELEASED: begin
					held_q[lk_q]  <= 1'b0;
					owner_q[lk_q] <= '0;
				end
				default: begin
					held_q[lk_q] <= cur_held;
				end
			endcase
		end
	end

	assign outcome     = outcome_q;
	assign woken_valid = woken_valid_q;
	assign woken_id    = woken_id_q;

endmodule

### hdl/fifo_mutex_lock_unit_core.sv
// Bank of mutex locks, each with an owner and a FIFO of blocked requesters.
// Input channel (in_valid / in_stall): one beat carries operation (wait or
// signal), lock_index and requester_id. Output channel (out_valid /
// out_stall): one beat per input beat, carrying outcome, woken_valid and
// woken_id, in request order.
// The result beat is presented from the output register, which is loaded
// by the update step once the input beat has been captured.
// A new item is taken only after the previous one has been committed; the
// capture step reads the lock's queue head from its memory port, the update
// step updates that lock's state and loads the output register.
// While a result waits in the output register, the next item is taken and
// looked up; it completes once the waiting beat leaves. A stalled output
// holds its beat unchanged.
// Reset: all locks free, owners zero, queues empty; no clearing pass is run,
// so items can be taken as soon as reset is released.
module fifo_mutex_lock_unit_core #(
	parameter int LOCK_COUNT      = 4,
	parameter int QUEUE_DEPTH     = 8,
	parameter int REQUESTER_COUNT = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [fmlu_pkg::OP_W-1:0]      operation,
	input  logic [fmlu_pkg::IDX_W-1:0]     lock_index,
	input  logic [fmlu_pkg::ID_W-1:0]      requester_id,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [fmlu_pkg::OUTCOME_W-1:0] outcome,
	output logic                           woken_valid,
	output logic [fmlu_pkg::ID_W-1:0]      woken_id
);
	import fmlu_pkg::*;

	dp_cmd_t cmd;

	fmlu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	fmlu_dp #(
		.LOCK_COUNT      (LOCK_COUNT),
		.QUEUE_DEPTH     (QUEUE_DEPTH),
		.REQUESTER_COUNT (REQUESTER_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.operation    (operation),
		.lock_index   (lock_index),
		.requester_id (requester_id),
		.outcome      (outcome),
		.woken_valid  (woken_valid),
		.woken_id     (woken_id)
	);

endmodule

### tb/sv/testbench.sv
localparam int LOCKS = 4;
localparam int DEPTH = 8;
localparam int PROCS = 16;

typedef struct packed {
	fmlu_pkg::outcome_t              outcome;
	logic                            woken_valid;
	logic [fmlu_pkg::ID_W-1:0]       woken_id;
} lock_reply_t;

class lock_book;
	bit                        held [LOCKS];
	logic [fmlu_pkg::ID_W-1:0] owner [LOCKS];
	logic [fmlu_pkg::ID_W-1:0] waiters [LOCKS][DEPTH];
	int unsigned               head [LOCKS];
	int unsigned               count [LOCKS];
	lock_reply_t               due [$];
	int unsigned               errors;

	function new();
		for (int i = 0; i < LOCKS; i++) begin
			held[i] = 1'b0;
			owner[i] = '0;
			head[i] = 0;
			count[i] = 0;
			for (int j = 0; j < DEPTH; j++)
				waiters[i][j] = '0;
		end
		errors = 0;
	endfunction

	function void note_request(logic [fmlu_pkg::OP_W-1:0] op,
			logic [fmlu_pkg::IDX_W-1:0] idx, logic [fmlu_pkg::ID_W-1:0] who);
		lock_reply_t reply;
		int unsigned slot;
		reply.outcome = fmlu_pkg::OUT_IGNORED;
		reply.woken_valid = 1'b0;
		reply.woken_id = '0;
		if (idx >= LOCKS || who >= PROCS) begin
			reply.outcome = fmlu_pkg::OUT_IGNORED;
		end else if (op == fmlu_pkg::OP_WAIT) begin
			if (!held[idx]) begin
				held[idx] = 1'b1;
				owner[idx] = who;
				reply.outcome = fmlu_pkg::OUT_GRANTED;
			end else if (count[idx] >= DEPTH) begin
				reply.outcome = fmlu_pkg::OUT_FULL;
			end else begin
				slot = (head[idx] + count[idx]) % DEPTH;
				waiters[idx][slot] = who;
				count[idx]++;
				reply.outcome = fmlu_pkg::OUT_QUEUED;
			end
		end else if (held[idx] && owner[idx] == who) begin
			if (count[idx] > 0) begin
				owner[idx] = waiters[idx][head[idx]];
				head[idx] = (head[idx] + 1) % DEPTH;
				count[idx]--;
				reply.outcome = fmlu_pkg::OUT_HANDED;
				reply.woken_valid = 1'b1;
				reply.woken_id = owner[idx];
			end else begin
				held[idx] = 1'b0;
				owner[idx] = '0;
				reply.outcome = fmlu_pkg::OUT_RELEASED;
			end
		end
		due.push_back(reply);
	endfunction

	function void note_error(string msg);
		errors++;
		if (errors <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endfunction

	function void check_result(logic [fmlu_pkg::OUTCOME_W-1:0] got_outcome,
			logic got_valid, logic [fmlu_pkg::ID_W-1:0] got_id);
		lock_reply_t exp;
		if (due.size() == 0) begin
			note_error($sformatf("unexpected beat outcome=%0d woken_valid=%0d woken_id=%0d",
				got_outcome, got_valid, got_id));
			return;
		end
		exp = due.pop_front();
		if (exp.outcome !== got_outcome || exp.woken_valid !== got_valid ||
				exp.woken_id !== got_id)
			note_error($sformatf({"expected outcome=%0d woken_valid=%0d woken_id=%0d, ",
				"got outcome=%0d woken_valid=%0d woken_id=%0d"},
				exp.outcome, exp.woken_valid, exp.woken_id, got_outcome, got_valid, got_id));
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS      = 900;
	localparam int CALM_ITEMS = 150;
	localparam int HANG_LIMIT = 1000;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [fmlu_pkg::OP_W-1:0]      operation = '0;
	logic [fmlu_pkg::IDX_W-1:0]     lock_index = '0;
	logic [fmlu_pkg::ID_W-1:0]      requester_id = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [fmlu_pkg::OUTCOME_W-1:0] outcome;
	logic                           woken_valid;
	logic [fmlu_pkg::ID_W-1:0]      woken_id;

	lock_book    book = new();
	bit          calm = 1'b0;
	int unsigned sent = 0;
	int unsigned gap_pct = 20;
	int unsigned hang_cycles = 0;

	fifo_mutex_lock_unit_core #(
		.LOCK_COUNT(LOCKS),
		.QUEUE_DEPTH(DEPTH),
		.REQUESTER_COUNT(PROCS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.lock_index(lock_index),
		.requester_id(requester_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.outcome(outcome),
		.woken_valid(woken_valid),
		.woken_id(woken_id)
	);

	always #1 clk = ~clk;

	task automatic send_request(logic [fmlu_pkg::OP_W-1:0] op,
			logic [fmlu_pkg::IDX_W-1:0] idx, logic [fmlu_pkg::ID_W-1:0] who);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		lock_index <= idx;
		requester_id <= who;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		book.note_request(op, idx, who);
		sent++;
	endtask

	task automatic wait_until_settled();
		in_valid <= 1'b0;
		while (book.due.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_signal_by_owner(logic [fmlu_pkg::IDX_W-1:0] idx);
		logic [fmlu_pkg::ID_W-1:0] who;
		who = 4'($urandom_range(0, PROCS - 1));
		if (book.held[idx] && $urandom_range(0, 3) != 0)
			who = book.owner[idx];
		send_request(fmlu_pkg::OP_SIGNAL, idx, who);
	endtask

	initial begin
		logic [fmlu_pkg::ID_W-1:0]  line_up [DEPTH];
		logic [fmlu_pkg::ID_W-1:0]  prev;
		logic [fmlu_pkg::IDX_W-1:0] idx;
		bit                         pressed;
		line_up = '{4'd0, 4'd15, 4'd15, 4'd3, 4'd7, 4'd9, 4'd12, 4'd10};
		pressed = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(fmlu_pkg::OP_WAIT, 2'd0, 4'd0);
		send_request(fmlu_pkg::OP_SIGNAL, 2'd0, 4'd5);
		send_request(fmlu_pkg::OP_SIGNAL, 2'd1, 4'd9);
		// owner queues behind itself, then duplicates and fill to overflow
		foreach (line_up[i])
			send_request(fmlu_pkg::OP_WAIT, 2'd0, line_up[i]);
		send_request(fmlu_pkg::OP_WAIT, 2'd0, 4'd6);
		prev = 4'd0;
		foreach (line_up[i]) begin
			send_request(fmlu_pkg::OP_SIGNAL, 2'd0, prev);
			prev = line_up[i];
		end
		send_request(fmlu_pkg::OP_SIGNAL, 2'd0, prev);
		send_request(fmlu_pkg::OP_WAIT, 2'd3, 4'd15);
		send_request(fmlu_pkg::OP_SIGNAL, 2'd3, 4'd15);
		send_request(fmlu_pkg::OP_WAIT, 2'd2, 4'd8);
		send_request(fmlu_pkg::OP_SIGNAL, 2'd2, 4'd8);
		wait_until_settled();

		while (sent < ITEMS) begin
			if (sent >= ITEMS - CALM_ITEMS)
				calm = 1'b1;
			if (!pressed && sent >= ITEMS / 2) begin
				wait_until_settled();
				pressed = 1'b1;
			end
			gap_pct = $urandom_range(0, 2) * 15;
			idx = 2'($urandom_range(0, LOCKS - 1));
			case ($urandom_range(0, 9))
				0, 1: begin
					repeat ($urandom_range(3, 11))
						send_request(fmlu_pkg::OP_WAIT, idx, 4'($urandom_range(0, PROCS - 1)));
				end
				2, 3: begin
					repeat ($urandom_range(2, 10))
						send_signal_by_owner(idx);
				end
				4, 5, 6, 7: begin
					repeat (8) begin
						if ($urandom_range(0, 1) == 0)
							send_request(fmlu_pkg::OP_WAIT, idx,
								4'($urandom_range(0, PROCS - 1)));
						else
							send_signal_by_owner(idx);
					end
				end
				default: begin
					repeat (4)
						send_request(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
							4'($urandom_range(0, 15)));
				end
			endcase
		end

		wait_until_settled();
		repeat (8) @(posedge clk);
		if (book.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		int unsigned stall_pct;
		stall_pct = 20;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0)
				stall_pct = $urandom_range(0, 2) * 20;
			if (!calm && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			book.check_result(outcome, woken_valid, woken_id);
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
			hang_cycles = 0;
		else
			hang_cycles++;
		if (hang_cycles >= HANG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end
endmodule

### fifo_mutex_lock_unit_core.f
+incdir+hdl
hdl/fmlu_pkg.sv
hdl/fmlu_ctrl.sv
hdl/fmlu_dp.sv
hdl/fifo_mutex_lock_unit_core.sv
tb/sv/testbench.sv
